### rtl/core/slre_pkg.sv
// Package for the segment LCD render engine: constants, codes, microcode and char table.
package slre_pkg;

    localparam int DIGIT_COUNT = 4;

    localparam logic [7:0] CURSOR_ROW0 = 8'h80;
    localparam logic [7:0] CURSOR_ROW1 = 8'hC0;
    localparam logic [7:0] BLANK_GLYPH = 8'h20;
    localparam logic [7:0] ALL_ON      = 8'hFF;

    // glyph codes of the custom characters
    localparam logic [7:0] GLY_TOP      = 8'd0;
    localparam logic [7:0] GLY_RIGHT    = 8'd1;
    localparam logic [7:0] GLY_BOTTOM   = 8'd2;
    localparam logic [7:0] GLY_LEFT     = 8'd3;
    localparam logic [7:0] GLY_MID      = 8'd4;
    localparam logic [7:0] GLY_MID_BOT  = 8'd5;
    localparam logic [7:0] GLY_POINT    = 8'd6;
    localparam logic [7:0] GLY_RIGHT_PT = 8'd7;

    typedef enum logic [2:0] {
        MODE_SHOW       = 3'd0,
        MODE_SET_SEG    = 3'd1,
        MODE_CLR_RENDER = 3'd2,
        MODE_RENDER     = 3'd3,
        MODE_ON_RENDER  = 3'd4
    } t_mode;

    // byte source selected by a microcode word
    typedef enum logic [2:0] {
        SRC_CUR_TOP = 3'd0,
        SRC_F       = 3'd1,
        SRC_A       = 3'd2,
        SRC_B       = 3'd3,
        SRC_CUR_BOT = 3'd4,
        SRC_E       = 3'd5,
        SRC_GD      = 3'd6,
        SRC_CP      = 3'd7
    } t_src;

    typedef struct packed {
        t_src       src;
        logic       rs;      // 1 data, 0 command
        logic       jump;    // end of digit: loop back or finish
        logic [2:0] target;  // jump target step
    } t_ucode;

    localparam logic [2:0] UC_LOOP      = 3'd0;

    // render program: one word per byte of a digit
    function automatic t_ucode uc_rom(input logic [2:0] step);
        t_ucode w;
        w = '{src: SRC_CUR_TOP, rs: 1'b0, jump: 1'b0, target: UC_LOOP};
        case (step)
            3'd0: w = '{src: SRC_CUR_TOP, rs: 1'b0, jump: 1'b0, target: UC_LOOP};
            3'd1: w = '{src: SRC_F,       rs: 1'b1, jump: 1'b0, target: UC_LOOP};
            3'd2: w = '{src: SRC_A,       rs: 1'b1, jump: 1'b0, target: UC_LOOP};
            3'd3: w = '{src: SRC_B,       rs: 1'b1, jump: 1'b0, target: UC_LOOP};
            3'd4: w = '{src: SRC_CUR_BOT, rs: 1'b0, jump: 1'b0, target: UC_LOOP};
            3'd5: w = '{src: SRC_E,       rs: 1'b1, jump: 1'b0, target: UC_LOOP};
            3'd6: w = '{src: SRC_GD,      rs: 1'b1, jump: 1'b0, target: UC_LOOP};
            3'd7: w = '{src: SRC_CP,      rs: 1'b1, jump: 1'b1, target: UC_LOOP};
            default: w = '{src: SRC_CUR_TOP, rs: 1'b0, jump: 1'b0, target: UC_LOOP};
        endcase
        return w;
    endfunction

    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // seven-segment pattern of an ASCII code; unknown codes are blank
    function automatic logic [7:0] char_pattern(input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] pat;
        c   = ch;
        pat = 8'h00;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            pat = DIGIT_CODES[ch[3:0]];
        end else begin
            if (ch >= 8'h61 && ch <= 8'h7A) begin
                c = ch - 8'h20;
            end
            case (c)
                8'h4C:   pat = 8'h38;  // L
                8'h47:   pat = 8'h3D;  // G
                8'h2D:   pat = 8'h40;  // minus
                8'h45:   pat = 8'h79;  // E
                8'h46:   pat = 8'h71;  // F
                8'h55:   pat = 8'h3E;  // U
                default: pat = 8'h00;
            endcase
        end
        return pat;
    endfunction

endpackage

### rtl/core/segment_lcd_render_engine_core.sv
// Segment LCD render engine: digit mask store and microcoded render sequencer.
//
// Usage:
//   Command channel: an item (i_mode, i_digit, i_char_code, i_dot, i_segment_index,
//   i_segment_on) is taken at a rising edge with start high and busy low.
//   Show-character and set-segment update the digit mask at that edge and
//   produce no output; the next item can follow in the very next cycle.
//   The three render modes raise busy while a microcode program of
//   eight words (one per byte of a digit) is stepped twice per word (high,
//   then low nibble) for each of the four digits. Clear and all-on modes
//   rewrite the masks at the accepting edge, before the first byte.
//   Result channel: o_strobe marks each expander byte for one cycle; the
//   transfer completes at the edge ending that cycle. The accepting edge loads
//   the sequencer registers, then the output registers present the first byte;
//   the 64th carries o_last. The receiver cannot stall this channel.
//   Throughput: one byte per cycle from the single sequencer while a render
//   runs; mask updates are taken one per cycle while idle. Config: i_cfg_we writes
//   the backlight bit; the user writes it only while idle (block does not enforce).
//   Reset (i_rst_n low, synchronous): masks clear, backlight is on,
//   sequencer idles and no strobe is driven.
module segment_lcd_render_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_mode,
    input  logic [1:0] i_digit,
    input  logic [7:0] i_char_code,
    input  logic       i_dot,
    input  logic [2:0] i_segment_index,
    input  logic       i_segment_on,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output logic       o_strobe,
    output logic [7:0] o_expander_byte,
    output logic       o_last
);
    import slre_pkg::*;

    localparam logic [1:0] LAST_DIGIT = 2'(DIGIT_COUNT - 1);

    logic [7:0] r_store [DIGIT_COUNT];
    logic       r_backlight;

    // sequencer state
    logic       r_run,   n_run;
    logic [2:0] r_step,  n_step;
    logic       r_half,  n_half;
    logic [1:0] r_digit, n_digit;

    // output registers
    logic       r_strobe;
    logic [7:0] r_byte;
    logic       r_last;

    logic       accept;
    logic       digit_ok;
    logic       do_render;
    t_ucode     uc;
    logic [7:0] s;
    logic [7:0] src_byte;
    logic [3:0] nib;
    logic       run_last;

    assign accept   = start && !busy;
    assign digit_ok = {1'b0, i_digit} < 3'(DIGIT_COUNT);
    assign busy     = r_run;

    always_comb begin
        case (t_mode'(i_mode))
            MODE_CLR_RENDER, MODE_RENDER, MODE_ON_RENDER: do_render = 1'b1;
            default:                                      do_render = 1'b0;
        endcase
    end

    // mask store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                r_store[k] <= 8'h00;
            end
        end else if (accept) begin
            case (t_mode'(i_mode))
                MODE_SHOW: begin
                    if (digit_ok) begin
                        r_store[i_digit] <= char_pattern(i_char_code) | {i_dot, 7'b0};
                    end
                end
                MODE_SET_SEG: begin
                    if (digit_ok) begin
                        r_store[i_digit][i_segment_index] <= i_segment_on;
                    end
                end
                MODE_CLR_RENDER: begin
                    for (int k = 0; k < DIGIT_COUNT; k++) begin
                        r_store[k] <= 8'h00;
                    end
                end
                MODE_ON_RENDER: begin
                    for (int k = 0; k < DIGIT_COUNT; k++) begin
                        r_store[k] <= ALL_ON;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
        end else if (i_cfg_we) begin
            r_backlight <= i_cfg_wdata;
        end
    end

    // datapath: the control word picks the byte for the current digit
    assign uc = uc_rom(r_step);
    assign s  = r_store[r_digit];

    always_comb begin
        case (uc.src)
            SRC_CUR_TOP: src_byte = CURSOR_ROW0 | {4'b0000, r_digit, 2'b00};
            SRC_F:       src_byte = s[5] ? GLY_LEFT  : BLANK_GLYPH;
            SRC_A:       src_byte = s[0] ? GLY_TOP   : BLANK_GLYPH;
            SRC_B:       src_byte = s[1] ? GLY_RIGHT : BLANK_GLYPH;
            SRC_CUR_BOT: src_byte = CURSOR_ROW1 | {4'b0000, r_digit, 2'b00};
            SRC_E:       src_byte = s[4] ? GLY_LEFT  : BLANK_GLYPH;
            SRC_GD:      src_byte = (s[6] && s[3]) ? GLY_MID_BOT :
                                    s[6] ? GLY_MID : s[3] ? GLY_BOTTOM : BLANK_GLYPH;
            SRC_CP:      src_byte = (s[2] && s[7]) ? GLY_RIGHT_PT :
                                    s[7] ? GLY_POINT : s[2] ? GLY_RIGHT : BLANK_GLYPH;
            default:     src_byte = BLANK_GLYPH;
        endcase
    end

    assign nib      = r_half ? src_byte[3:0] : src_byte[7:4];
    assign run_last = uc.jump && r_half && (r_digit == LAST_DIGIT);

    // step counter, nibble phase, digit counter; jump at end of each digit
    always_comb begin
        n_run   = r_run;
        n_step  = r_step;
        n_half  = r_half;
        n_digit = r_digit;
        if (r_run) begin
            n_half = !r_half;
            if (r_half) begin
                if (uc.jump) begin
                    n_step = uc.target;
                    if (r_digit == LAST_DIGIT) begin
                        n_run   = 1'b0;
                        n_digit = 2'd0;
                    end else begin
                        n_digit = r_digit + 2'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
        end else if (accept && do_render) begin
            n_run   = 1'b1;
            n_step  = UC_LOOP;
            n_half  = 1'b0;
            n_digit = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_step   <= UC_LOOP;
            r_half   <= 1'b0;
            r_digit  <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_run    <= n_run;
            r_step   <= n_step;
            r_half   <= n_half;
            r_digit  <= n_digit;
            r_strobe <= r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= {nib, r_backlight, 2'b00, uc.rs};
        r_last <= r_run && run_last;
    end

    assign o_strobe        = r_strobe;
    assign o_expander_byte = r_byte;
    assign o_last          = r_last && r_strobe;

`ifndef SYNTHESIS
    a_strobe_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("strobe without a running sequencer");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_strobe)
        else $error("byte transfer right after the last byte");

    a_render_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_RENDER || i_mode == MODE_CLR_RENDER ||
                    i_mode == MODE_ON_RENDER)) |=> busy)
        else $error("render accepted but sequencer idle");

    // busy is unknown before the first reset edge, so skip the edge after it
    a_busy_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (r_last && r_strobe == $past(r_run)))
        else $error("sequencer stopped before the last byte");
`endif

endmodule

### dv/segment_lcd_render_engine_core_test.sv
// Self-checking testbench of the segment LCD render engine core.
`timescale 1ns / 100ps

module segment_lcd_render_engine_core_test;
    import slre_pkg::*;

    // Segment bit positions inside a digit mask
    localparam logic [2:0] SEG_A     = 3'd0;
    localparam logic [2:0] SEG_B     = 3'd1;
    localparam logic [2:0] SEG_C     = 3'd2;
    localparam logic [2:0] SEG_D     = 3'd3;
    localparam logic [2:0] SEG_E     = 3'd4;
    localparam logic [2:0] SEG_F     = 3'd5;
    localparam logic [2:0] SEG_G     = 3'd6;
    localparam logic [2:0] SEG_POINT = 3'd7;

    // Mode codes with no function; the block must ignore them
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // Register select values of an expander byte
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Random items per idling phase
    localparam int PHASE_ITEMS = 48;

    // One command on the item channel
    typedef struct {
        t_mode      mode;
        logic [1:0] digit;
        logic [7:0] char_code;
        logic       dot;
        logic [2:0] seg_index;
        logic       seg_on;
    } t_lcd_cmd;

    // Digit mask shadow, backlight shadow and the queue of expander bytes
    // still owed by the block. Each entry is {last, expander_byte}.
    class lcd_scoreboard;
        logic [7:0] digit_mask [DIGIT_COUNT];
        logic       backlight;
        logic [8:0] expected_bytes [$];
        int         fails;

        function new();
            foreach (digit_mask[i]) digit_mask[i] = 8'h00;
            backlight = 1'b1;
            fails     = 0;
        endfunction

        // Seven-segment mask of an ASCII code; letters fold to upper case
        static function logic [7:0] segment_code(logic [7:0] ch);
            logic [7:0] up;
            up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
            case (up)
                8'h30:   return 8'h3F;
                8'h31:   return 8'h06;
                8'h32:   return 8'h5B;
                8'h33:   return 8'h4F;
                8'h34:   return 8'h66;
                8'h35:   return 8'h6D;
                8'h36:   return 8'h7D;
                8'h37:   return 8'h07;
                8'h38:   return 8'h7F;
                8'h39:   return 8'h6F;
                8'h4C:   return 8'h38;   // L
                8'h47:   return 8'h3D;   // G
                8'h2D:   return 8'h40;   // minus
                8'h45:   return 8'h79;   // E
                8'h46:   return 8'h71;   // F
                8'h55:   return 8'h3E;   // U
                default: return 8'h00;
            endcase
        endfunction

        // One LCD byte as two expander transfers, high nibble first
        function void push_lcd_byte(logic [7:0] val, logic rs, logic is_last);
            expected_bytes.push_back({1'b0, val[7:4], backlight, 2'b00, rs});
            expected_bytes.push_back({is_last, val[3:0], backlight, 2'b00, rs});
        endfunction

        function void render_frame();
            logic [7:0] s;
            logic [7:0] col;
            logic [7:0] gd;
            logic [7:0] cp;
            logic       fin;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                s   = digit_mask[i];
                col = 8'(4 * i);
                fin = (i == DIGIT_COUNT - 1);
                gd  = (s[SEG_G] && s[SEG_D]) ? GLY_MID_BOT :
                      s[SEG_G] ? GLY_MID : s[SEG_D] ? GLY_BOTTOM : BLANK_GLYPH;
                cp  = (s[SEG_C] && s[SEG_POINT]) ? GLY_RIGHT_PT :
                      s[SEG_POINT] ? GLY_POINT : s[SEG_C] ? GLY_RIGHT : BLANK_GLYPH;
                push_lcd_byte(CURSOR_ROW0 | col, RS_CMD, 1'b0);
                push_lcd_byte(s[SEG_F] ? GLY_LEFT  : BLANK_GLYPH, RS_DATA, 1'b0);
                push_lcd_byte(s[SEG_A] ? GLY_TOP   : BLANK_GLYPH, RS_DATA, 1'b0);
                push_lcd_byte(s[SEG_B] ? GLY_RIGHT : BLANK_GLYPH, RS_DATA, 1'b0);
                push_lcd_byte(CURSOR_ROW1 | col, RS_CMD, 1'b0);
                push_lcd_byte(s[SEG_E] ? GLY_LEFT  : BLANK_GLYPH, RS_DATA, 1'b0);
                push_lcd_byte(gd, RS_DATA, 1'b0);
                push_lcd_byte(cp, RS_DATA, fin);
            end
        endfunction

        function void note_command(t_lcd_cmd c);
            logic [7:0] m;
            case (c.mode)
                MODE_SHOW: begin
                    if (c.digit < DIGIT_COUNT) begin
                        m = segment_code(c.char_code);
                        if (c.dot) m[SEG_POINT] = 1'b1;
                        digit_mask[c.digit] = m;
                    end
                end
                MODE_SET_SEG: begin
                    if (c.digit < DIGIT_COUNT) digit_mask[c.digit][c.seg_index] = c.seg_on;
                end
                MODE_CLR_RENDER: begin
                    foreach (digit_mask[i]) digit_mask[i] = 8'h00;
                    render_frame();
                end
                MODE_RENDER: begin
                    render_frame();
                end
                MODE_ON_RENDER: begin
                    foreach (digit_mask[i]) digit_mask[i] = ALL_ON;
                    render_frame();
                end
                default: ;
            endcase
        endfunction

        function void check_transfer(logic [7:0] xbyte, logic xlast);
            logic [8:0] want;
            if (expected_bytes.size() == 0) begin
                $error("expander_byte: no transfer expected, actual %h", xbyte);
                fails++;
                return;
            end
            want = expected_bytes.pop_front();
            if (xbyte !== want[7:0]) begin
                $error("expander_byte mismatch: expected %h actual %h", want[7:0], xbyte);
                fails++;
            end
            if (xlast !== want[8]) begin
                $error("last mismatch: expected %b actual %b", want[8], xlast);
                fails++;
            end
        endfunction
    endclass

    // Block ports; every input starts at a known value
    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       start           = 1'b0;
    logic       busy;
    logic [2:0] i_mode          = '0;
    logic [1:0] i_digit         = '0;
    logic [7:0] i_char_code     = '0;
    logic       i_dot           = 1'b0;
    logic [2:0] i_segment_index = '0;
    logic       i_segment_on    = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic       i_cfg_wdata     = 1'b0;
    logic       o_strobe;
    logic [7:0] o_expander_byte;
    logic       o_last;

    lcd_scoreboard sb;

    segment_lcd_render_engine_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_digit         (i_digit),
        .i_char_code     (i_char_code),
        .i_dot           (i_dot),
        .i_segment_index (i_segment_index),
        .i_segment_on    (i_segment_on),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // Monitor: samples ports as they stood before the edge. A result is
    // checked before a command taken at the same edge is noted, so the
    // expected queue stays in transfer order.
    always @(posedge i_clk) begin
        t_lcd_cmd c;
        if (i_rst_n) begin
            if (i_cfg_we) sb.backlight = i_cfg_wdata;
            if (o_strobe) sb.check_transfer(o_expander_byte, o_last);
            if (start && !busy) begin
                c.mode      = t_mode'(i_mode);
                c.digit     = i_digit;
                c.char_code = i_char_code;
                c.dot       = i_dot;
                c.seg_index = i_segment_index;
                c.seg_on    = i_segment_on;
                sb.note_command(c);
            end
        end
    end

    // Presents one command and holds it until the block takes it. With no
    // gap drawn, start stays high so the next command follows back to back.
    task automatic send_cmd(t_lcd_cmd c, int idle_pct);
        start           <= 1'b1;
        i_mode          <= c.mode;
        i_digit         <= c.digit;
        i_char_code     <= c.char_code;
        i_dot           <= c.dot;
        i_segment_index <= c.seg_index;
        i_segment_on    <= c.seg_on;
        do @(posedge i_clk); while (busy !== 1'b0);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic send_fields(logic [2:0] mode, logic [1:0] digit, logic [7:0] ch,
                               logic dot, logic [2:0] seg_index, logic seg_on);
        t_lcd_cmd c;
        c.mode      = t_mode'(mode);
        c.digit     = digit;
        c.char_code = ch;
        c.dot       = dot;
        c.seg_index = seg_index;
        c.seg_on    = seg_on;
        send_cmd(c, 0);
    endtask

    // Waits until every owed transfer has come and the sequencer is idle.
    // The first edge lets the monitor note a command taken at the last one.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_bytes.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_backlight(logic on);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly mask updates with renders in between; characters lean on the
    // ones with a glyph, the rest fall anywhere in the byte range.
    function automatic t_lcd_cmd random_cmd();
        string    known;
        int       pick;
        t_lcd_cmd c;
        known       = "0123456789LlGgEeFfUu- ";
        pick        = $urandom_range(99);
        c.digit     = 2'($urandom_range(3));
        c.dot       = 1'($urandom_range(1));
        c.seg_index = 3'($urandom_range(7));
        c.seg_on    = 1'($urandom_range(1));
        c.char_code = ($urandom_range(99) < 60) ? known[$urandom_range(known.len() - 1)]
                                                : 8'($urandom_range(255));
        if (pick < 40)      c.mode = MODE_SHOW;
        else if (pick < 68) c.mode = MODE_SET_SEG;
        else if (pick < 84) c.mode = MODE_RENDER;
        else if (pick < 89) c.mode = MODE_CLR_RENDER;
        else if (pick < 94) c.mode = MODE_ON_RENDER;
        else                c.mode = t_mode'(3'($urandom_range(MODE_SPARE_LAST,
                                                               MODE_SPARE_FIRST)));
        return c;
    endfunction

    initial begin
        int idle_pct [4];
        sb = new();
        // receiver stall phases look like no idling: results cannot be held
        idle_pct = '{0, 88, 0, 27};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every character class, dot handling, blank codes,
        // single-segment edits, ignored modes and all three render kinds
        send_fields(MODE_SHOW,    2'd0, 8'h38, 1'b1, 3'd0, 1'b0);  // '8' with point
        send_fields(MODE_SHOW,    2'd1, 8'h4C, 1'b0, 3'd0, 1'b0);  // 'L'
        send_fields(MODE_SHOW,    2'd2, 8'h67, 1'b0, 3'd0, 1'b0);  // 'g'
        send_fields(MODE_SHOW,    2'd3, 8'h2D, 1'b0, 3'd0, 1'b0);  // '-'
        send_fields(MODE_RENDER,  2'd0, 8'h00, 1'b0, 3'd0, 1'b0);
        send_fields(MODE_SHOW,    2'd0, 8'h65, 1'b0, 3'd0, 1'b0);  // 'e'
        send_fields(MODE_SHOW,    2'd1, 8'h46, 1'b1, 3'd0, 1'b0);  // 'F' with point
        send_fields(MODE_SHOW,    2'd2, 8'h75, 1'b0, 3'd0, 1'b0);  // 'u'
        send_fields(MODE_SHOW,    2'd3, 8'h20, 1'b1, 3'd0, 1'b0);  // space, point only
        send_fields(MODE_RENDER,  2'd0, 8'h00, 1'b0, 3'd0, 1'b0);
        send_fields(MODE_SHOW,    2'd0, 8'hFF, 1'b1, 3'd0, 1'b0);  // non-ASCII: blank
        send_fields(MODE_SHOW,    2'd1, 8'h5A, 1'b0, 3'd0, 1'b0);  // 'Z' has no glyph
        send_fields(MODE_SHOW,    2'd2, 8'h30, 1'b0, 3'd0, 1'b0);  // '0'
        send_fields(MODE_SHOW,    2'd3, 8'h39, 1'b0, 3'd0, 1'b0);  // '9'
        send_fields(MODE_SET_SEG, 2'd2, 8'h00, 1'b0, SEG_POINT, 1'b1);
        send_fields(MODE_SET_SEG, 2'd3, 8'h00, 1'b0, SEG_A, 1'b0);
        send_fields(MODE_SET_SEG, 2'd1, 8'h00, 1'b0, SEG_G, 1'b1);
        send_fields(MODE_SPARE_FIRST, 2'd3, 8'hFF, 1'b1, 3'd7, 1'b1);
        send_fields(MODE_SPARE_MID,   2'd2, 8'h38, 1'b1, 3'd7, 1'b1);
        send_fields(MODE_SPARE_LAST, 2'd1, 8'h31, 1'b1, 3'd0, 1'b0);
        send_fields(MODE_RENDER,  2'd0, 8'h00, 1'b0, 3'd0, 1'b0);
        send_fields(MODE_ON_RENDER, 2'd0, 8'h00, 1'b0, 3'd0, 1'b0);
        send_fields(MODE_SET_SEG, 2'd0, 8'h00, 1'b0, SEG_C, 1'b0);
        send_fields(MODE_RENDER,  2'd0, 8'h00, 1'b0, 3'd0, 1'b0);
        send_fields(MODE_CLR_RENDER, 2'd3, 8'hFF, 1'b1, 3'd7, 1'b1);
        wait_drained();

        // Random phases; backlight toggles between them, off for the two phases
        // with no idling and on for the two phases with idling
        for (int p = 0; p < 4; p++) begin
            write_backlight(p[0]);
            for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), idle_pct[p]);
            wait_drained();
        end

        if (sb.fails == 0 && sb.expected_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/slre_pkg.sv
rtl/core/segment_lcd_render_engine_core.sv
dv/segment_lcd_render_engine_core_test.sv
